[rtl/core/cdfc_pkg.sv]
// ----------------------------------------------------------------------------
// cdfc_pkg
// Shared types, access codes and the music divider helper for the data
// fetcher coprocessor.
// ----------------------------------------------------------------------------
package cdfc_pkg;

  localparam int CHANNELS    = 8;
  localparam int CH_W        = 3;
  localparam int COUNT_W     = 11;
  localparam int MUSIC_CH    = 3;
  localparam int MUSIC_FIRST = 5;
  localparam int ADDR_W      = 11;

  localparam logic [3:0] ACT_FETCH        = 4'd0;
  localparam logic [3:0] ACT_FETCH_MASKED = 4'd1;
  localparam logic [3:0] ACT_READ_FLAG    = 4'd2;
  localparam logic [3:0] ACT_RANDOM       = 4'd3;
  localparam logic [3:0] ACT_SOUND        = 4'd4;
  localparam logic [3:0] ACT_NULL_READ    = 4'd5;
  localparam logic [3:0] ACT_TOP          = 4'd6;
  localparam logic [3:0] ACT_BOTTOM       = 4'd7;
  localparam logic [3:0] ACT_COUNT_LOW    = 4'd8;
  localparam logic [3:0] ACT_COUNT_HIGH   = 4'd9;
  localparam logic [3:0] ACT_RESET_RANDOM = 4'd10;
  localparam logic [3:0] ACT_MUSIC_TICK   = 4'd11;
  localparam logic [3:0] ACT_LOAD_STORE   = 4'd12;

  localparam logic [9:0] RELOAD_MARK = 10'h3ff;

  // 129 / 79 as a fixed-point reciprocal: 129 * ceil(2^22 / 79).
  localparam logic [30:0] TUNE_MUL   = 31'd6848997;
  localparam int          TUNE_SHIFT = 22;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } store_req_t;

  function automatic logic [8:0] tune(input logic [7:0] d);
    logic [30:0] p;
    p = 31'(d) * TUNE_MUL;
    return p[TUNE_SHIFT+8:TUNE_SHIFT];
  endfunction

endpackage

[rtl/core/cdfc_store.sv]
// ----------------------------------------------------------------------------
// cdfc_store
// Graphics store: one write and one registered read per cycle, with accesses
// beyond the configured depth ignored on write and read back as zero.
// ----------------------------------------------------------------------------
module cdfc_store #(
  parameter int STORE_DEPTH = 2048
) (
  input  logic                 clk,
  input  cdfc_pkg::store_req_t req,
  output logic [7:0]           rd_data
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam logic [12:0] DEPTH_EXT = 13'(STORE_DEPTH);

  logic [7:0]    mem [STORE_DEPTH];
  logic [7:0]    mem_q;
  logic          rd_ok;
  logic [12:0]   wr_ext;
  logic [12:0]   rd_ext;
  logic [AW-1:0] wr_idx;
  logic [AW-1:0] rd_idx;
  logic          wr_in;
  logic          rd_in;

  assign wr_ext = {2'b00, req.wr_addr};
  assign rd_ext = {2'b00, req.rd_addr};
  assign wr_idx = wr_ext[AW-1:0];
  assign rd_idx = rd_ext[AW-1:0];
  assign wr_in  = wr_ext < DEPTH_EXT;
  assign rd_in  = rd_ext < DEPTH_EXT;

  always_ff @(posedge clk) begin
    if (req.wr_en && wr_in) begin
      mem[wr_idx] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_ok <= rd_in;
      if (rd_in) begin
        mem_q <= mem[rd_idx];
      end
    end
  end

  assign rd_data = rd_ok ? mem_q : 8'h00;

endmodule

[rtl/core/cartridge_data_fetcher_coprocessor.sv]
// ----------------------------------------------------------------------------
// cartridge_data_fetcher_coprocessor
// Eight data-fetcher channels over a graphics store, a random byte source and
// a three-voice music generator with a mixed audio level.
// ----------------------------------------------------------------------------
// Usage:
// Each input beat on the s_ channel is one processor access or music tick.
// The access code and channel ride in s_tuser; the data byte and the store
// address ride in s_tdata. Every input beat yields exactly one output beat on
// the m_ channel carrying the read byte and the audio level after the access.
// The mix table is written through the cfg_ channel, which is always ready;
// write it only while no beats are in flight.
// Throughput is one beat per cycle while m_tready stays high. An accepted
// beat passes the read stage, with the registered store read, and then the
// output register before m_tvalid. Channel state lives in registers updated
// in the accept cycle, so back-to-back accesses to one channel see each other.
// Reset clears all channel and music state, sets the random register to one
// and clears the pipeline; the store holds no reset value and needs no
// clearing pass. When m_tready is low the output register and the read stage
// hold, and s_tready drops once both are full.
// ----------------------------------------------------------------------------
module cartridge_data_fetcher_coprocessor #(
  parameter int STORE_DEPTH = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // data_in[7:0], store_address[18:8], zero pad
  input  logic [6:0]  s_tuser,   // action[3:0], channel[6:4]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // read_data[7:0], audio_level[15:8]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data
);

  localparam int NCH = cdfc_pkg::CHANNELS;
  localparam int NMU = cdfc_pkg::MUSIC_CH;
  localparam int MF  = cdfc_pkg::MUSIC_FIRST;

  logic [63:0] mix_table;

  logic [7:0]                   top_cmp        [NCH];
  logic [7:0]                   bot_cmp        [NCH];
  logic [cdfc_pkg::COUNT_W-1:0] fetch_cnt      [NCH];
  logic                         win_flag       [NCH];
  logic [7:0]                   top_cmp_next   [NCH];
  logic [7:0]                   bot_cmp_next   [NCH];
  logic [cdfc_pkg::COUNT_W-1:0] fetch_cnt_next [NCH];
  logic                         win_flag_next  [NCH];

  logic       mus_en        [NMU];
  logic [8:0] mus_top       [NMU];
  logic [8:0] mus_bot       [NMU];
  logic [9:0] mus_cnt       [NMU];
  logic       mus_en_next   [NMU];
  logic [8:0] mus_top_next  [NMU];
  logic [8:0] mus_bot_next  [NMU];
  logic [9:0] mus_cnt_next  [NMU];

  logic [7:0] rand_sr;
  logic [7:0] rand_sr_next;
  logic [7:0] sound;
  logic [7:0] sound_next;

  logic [3:0]                   action;
  logic [cdfc_pkg::CH_W-1:0]    ch;
  logic [7:0]                   din;
  logic [cdfc_pkg::ADDR_W-1:0]  saddr;
  logic [2:0]                   mdiff;
  logic [1:0]                   m;
  logic                         is_music;
  logic [7:0]                   cnt_low;
  logic                         fetch_flag;
  logic                         rand_fb;
  logic [8:0]                   tuned;
  logic [2:0]                   mix_idx;

  logic       accept;
  logic       p1_valid;
  logic       p1_use_mem;
  logic [7:0] p1_rd;
  logic [7:0] p1_sound;
  logic       p1_move;
  logic       use_mem;
  logic [7:0] rd_val;

  logic       out_valid;
  logic [7:0] out_rd;
  logic [7:0] out_sound;

  cdfc_pkg::store_req_t store_req;
  logic [7:0]           store_q;

  assign action = s_tuser[3:0];
  assign ch     = s_tuser[6:4];
  assign din    = s_tdata[7:0];
  assign saddr  = s_tdata[18:8];

  assign p1_move  = p1_valid && (!out_valid || m_tready);
  assign s_tready = !p1_valid || p1_move;
  assign accept   = s_tvalid && s_tready;

  assign cfg_ready = 1'b1;

  assign mdiff    = ch - 3'(MF);
  assign m        = mdiff[1:0];
  assign is_music = ch >= 3'(MF);
  assign cnt_low  = fetch_cnt[ch][7:0];
  assign tuned    = cdfc_pkg::tune(din);
  assign rand_fb  = ~(rand_sr[7] ^ rand_sr[5] ^ rand_sr[4] ^ rand_sr[3]);

  always_comb begin
    if (cnt_low == bot_cmp[ch]) begin
      fetch_flag = 1'b0;
    end else if (cnt_low == top_cmp[ch]) begin
      fetch_flag = 1'b1;
    end else begin
      fetch_flag = win_flag[ch];
    end
  end

  always_comb begin
    top_cmp_next   = top_cmp;
    bot_cmp_next   = bot_cmp;
    fetch_cnt_next = fetch_cnt;
    win_flag_next  = win_flag;
    mus_en_next    = mus_en;
    mus_top_next   = mus_top;
    mus_bot_next   = mus_bot;
    mus_cnt_next   = mus_cnt;
    rand_sr_next   = rand_sr;
    sound_next     = sound;
    rd_val         = din;
    use_mem        = 1'b0;
    mix_idx        = 3'd0;
    store_req      = '0;
    store_req.wr_addr = saddr;
    store_req.wr_data = din;
    store_req.rd_addr = ~fetch_cnt[ch];
    if (accept) begin
      unique case (action)
        cdfc_pkg::ACT_FETCH, cdfc_pkg::ACT_FETCH_MASKED: begin
          win_flag_next[ch]  = fetch_flag;
          fetch_cnt_next[ch] = fetch_cnt[ch] - 1'b1;
          store_req.rd_en    = 1'b1;
          use_mem            = (action == cdfc_pkg::ACT_FETCH) || fetch_flag;
          rd_val             = 8'h00;
        end
        cdfc_pkg::ACT_READ_FLAG: begin
          rd_val = win_flag[ch] ? 8'hff : 8'h00;
        end
        cdfc_pkg::ACT_RANDOM: begin
          rand_sr_next = {rand_sr[6:0], rand_fb};
          rd_val       = {rand_sr[6:0], rand_fb};
        end
        cdfc_pkg::ACT_SOUND: begin
          rd_val = sound;
        end
        cdfc_pkg::ACT_NULL_READ: begin
          rd_val = 8'h00;
        end
        cdfc_pkg::ACT_TOP: begin
          top_cmp_next[ch] = din;
          if (is_music) begin
            mus_top_next[m] = tuned;
          end
        end
        cdfc_pkg::ACT_BOTTOM: begin
          bot_cmp_next[ch] = din;
          if (is_music) begin
            mus_bot_next[m] = tuned;
          end
        end
        cdfc_pkg::ACT_COUNT_LOW: begin
          fetch_cnt_next[ch][7:0] = din;
          if (is_music) begin
            mus_cnt_next[m] = {1'b0, tuned};
          end
        end
        cdfc_pkg::ACT_COUNT_HIGH: begin
          fetch_cnt_next[ch][10:8] = din[2:0];
          win_flag_next[ch]        = 1'b0;
          if (is_music) begin
            mus_en_next[m] = din[4];
          end
        end
        cdfc_pkg::ACT_RESET_RANDOM: begin
          rand_sr_next = 8'h01;
        end
        cdfc_pkg::ACT_MUSIC_TICK: begin
          for (int k = 0; k < NMU; k++) begin
            if (mus_en[k]) begin
              if (mus_cnt[k] == {1'b0, mus_bot[k]}) begin
                win_flag_next[MF+k] = 1'b0;
                mus_cnt_next[k]     = mus_cnt[k] - 1'b1;
              end else if (mus_cnt[k] == cdfc_pkg::RELOAD_MARK) begin
                mus_cnt_next[k]     = {1'b0, mus_top[k]};
                win_flag_next[MF+k] = 1'b1;
              end else begin
                mus_cnt_next[k] = mus_cnt[k] - 1'b1;
              end
            end
          end
          mix_idx    = {win_flag_next[MF+2], win_flag_next[MF+1], win_flag_next[MF]};
          sound_next = mix_table[{mix_idx, 3'b000} +: 8];
        end
        cdfc_pkg::ACT_LOAD_STORE: begin
          store_req.wr_en = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mix_table <= '0;
      for (int i = 0; i < NCH; i++) begin
        top_cmp[i]   <= '0;
        bot_cmp[i]   <= '0;
        fetch_cnt[i] <= '0;
        win_flag[i]  <= 1'b0;
      end
      for (int k = 0; k < NMU; k++) begin
        mus_en[k]  <= 1'b0;
        mus_top[k] <= '0;
        mus_bot[k] <= '0;
        mus_cnt[k] <= '0;
      end
      rand_sr <= 8'h01;
      sound   <= '0;
    end else begin
      if (cfg_valid) begin
        mix_table <= cfg_data;
      end
      top_cmp   <= top_cmp_next;
      bot_cmp   <= bot_cmp_next;
      fetch_cnt <= fetch_cnt_next;
      win_flag  <= win_flag_next;
      mus_en    <= mus_en_next;
      mus_top   <= mus_top_next;
      mus_bot   <= mus_bot_next;
      mus_cnt   <= mus_cnt_next;
      rand_sr   <= rand_sr_next;
      sound     <= sound_next;
    end
  end

  cdfc_store #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .req     (store_req),
    .rd_data (store_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        p1_valid <= 1'b1;
      end else if (p1_move) begin
        p1_valid <= 1'b0;
      end
      if (p1_move) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_use_mem <= use_mem;
      p1_rd      <= rd_val;
      p1_sound   <= sound_next;
    end
    if (p1_move) begin
      out_rd    <= p1_use_mem ? store_q : p1_rd;
      out_sound <= p1_sound;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_sound, out_rd};

endmodule

[bench/cartridge_data_fetcher_coprocessor_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cartridge_data_fetcher_coprocessor_tb
// Self-checking bench for the data fetcher coprocessor. A directed opening
// covers field extremes and every access kind, then random fetch windows, music
// setups with tick bursts and single noise accesses run under several mix
// tables. A scoreboard class predicts each output beat and checks it in order,
// while both stream sides idle and stall at random in all but one phase.
// ----------------------------------------------------------------------------
module cartridge_data_fetcher_coprocessor_tb;

  localparam logic [3:0] ACT_SPARE_LO  = 4'd13;
  localparam logic [3:0] ACT_SPARE_MID = 4'd14;
  localparam logic [3:0] ACT_SPARE_HI  = 4'd15;
  localparam int STORE_DEPTH  = 2048;
  localparam int RANDOM_ITEMS = 2000;
  localparam int PHASES       = 4;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct {
    logic [7:0] read_data;
    logic [7:0] audio_level;
  } beat_t;

  class access_scoreboard;
    logic [63:0] mix;
    logic [7:0]  top_cmp[cdfc_pkg::CHANNELS];
    logic [7:0]  bottom_cmp[cdfc_pkg::CHANNELS];
    logic [10:0] fetch_cnt[cdfc_pkg::CHANNELS];
    bit          window[cdfc_pkg::CHANNELS];
    bit          voice_on[cdfc_pkg::MUSIC_CH];
    logic [8:0]  voice_top[cdfc_pkg::MUSIC_CH];
    logic [8:0]  voice_bottom[cdfc_pkg::MUSIC_CH];
    logic [9:0]  voice_count[cdfc_pkg::MUSIC_CH];
    logic [7:0]  lfsr;
    logic [7:0]  level;
    logic [7:0]  store[STORE_DEPTH];
    bit          loaded[STORE_DEPTH];
    beat_t       expected_beats[$];
    int          errors;
    int          checked;

    function new();
      mix = '0;
      for (int i = 0; i < cdfc_pkg::CHANNELS; i++) begin
        top_cmp[i] = '0;
        bottom_cmp[i] = '0;
        fetch_cnt[i] = '0;
        window[i] = 1'b0;
      end
      for (int i = 0; i < cdfc_pkg::MUSIC_CH; i++) begin
        voice_on[i] = 1'b0;
        voice_top[i] = '0;
        voice_bottom[i] = '0;
        voice_count[i] = '0;
      end
      for (int i = 0; i < STORE_DEPTH; i++) begin
        store[i] = '0;
        loaded[i] = 1'b0;
      end
      lfsr = 8'h01;
      level = '0;
      errors = 0;
      checked = 0;
    endfunction

    function void set_mix(logic [63:0] v);
      mix = v;
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    function logic [8:0] scale_pitch(logic [7:0] d);
      int p;
      p = int'(d) * 129 / 79;
      return p[8:0];
    endfunction

    function logic [7:0] fetch_byte(int ch);
      logic [10:0] addr;
      if (fetch_cnt[ch][7:0] == top_cmp[ch]) window[ch] = 1'b1;
      if (fetch_cnt[ch][7:0] == bottom_cmp[ch]) window[ch] = 1'b0;
      addr = 11'h7ff - fetch_cnt[ch];
      fetch_cnt[ch] = fetch_cnt[ch] - 11'd1;
      return store[addr];
    endfunction

    function void advance_voices();
      logic [2:0] idx;
      for (int m = 0; m < cdfc_pkg::MUSIC_CH; m++) begin
        if (voice_on[m]) begin
          if (voice_count[m] == {1'b0, voice_bottom[m]}) begin
            window[cdfc_pkg::MUSIC_FIRST + m] = 1'b0;
            voice_count[m] = voice_count[m] - 10'd1;
          end else if (voice_count[m] == cdfc_pkg::RELOAD_MARK) begin
            voice_count[m] = {1'b0, voice_top[m]};
            window[cdfc_pkg::MUSIC_FIRST + m] = 1'b1;
          end else begin
            voice_count[m] = voice_count[m] - 10'd1;
          end
        end
      end
      idx = {window[7], window[6], window[5]};
      level = mix[8 * idx +: 8];
    endfunction

    function void note_access(logic [3:0] act, logic [2:0] ch, logic [7:0] d,
                              logic [10:0] sa);
      beat_t b;
      bit voice;
      int m;
      logic fb;
      voice = int'(ch) >= cdfc_pkg::MUSIC_FIRST;
      m = voice ? int'(ch) - cdfc_pkg::MUSIC_FIRST : 0;
      b.read_data = d;
      case (act)
        cdfc_pkg::ACT_FETCH: b.read_data = fetch_byte(ch);
        cdfc_pkg::ACT_FETCH_MASKED: begin
          b.read_data = fetch_byte(ch);
          if (!window[ch]) b.read_data = 8'h00;
        end
        cdfc_pkg::ACT_READ_FLAG: b.read_data = window[ch] ? 8'hff : 8'h00;
        cdfc_pkg::ACT_RANDOM: begin
          fb = ~(lfsr[7] ^ lfsr[5] ^ lfsr[4] ^ lfsr[3]);
          lfsr = {lfsr[6:0], fb};
          b.read_data = lfsr;
        end
        cdfc_pkg::ACT_SOUND: b.read_data = level;
        cdfc_pkg::ACT_NULL_READ: b.read_data = 8'h00;
        cdfc_pkg::ACT_TOP: begin
          top_cmp[ch] = d;
          if (voice) voice_top[m] = scale_pitch(d);
        end
        cdfc_pkg::ACT_BOTTOM: begin
          bottom_cmp[ch] = d;
          if (voice) voice_bottom[m] = scale_pitch(d);
        end
        cdfc_pkg::ACT_COUNT_LOW: begin
          fetch_cnt[ch][7:0] = d;
          if (voice) voice_count[m] = {1'b0, scale_pitch(d)};
        end
        cdfc_pkg::ACT_COUNT_HIGH: begin
          fetch_cnt[ch][10:8] = d[2:0];
          if (voice) voice_on[m] = d[4];
          window[ch] = 1'b0;
        end
        cdfc_pkg::ACT_RESET_RANDOM: lfsr = 8'h01;
        cdfc_pkg::ACT_MUSIC_TICK: advance_voices();
        cdfc_pkg::ACT_LOAD_STORE: begin
          store[sa] = d;
          loaded[sa] = 1'b1;
        end
        default: ;
      endcase
      b.audio_level = level;
      expected_beats.push_back(b);
    endfunction

    function void check_beat(logic [15:0] beat);
      beat_t want;
      checked++;
      if (expected_beats.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Output beat %0d (%h) arrived with nothing pending",
                                   checked, beat);
        return;
      end
      want = expected_beats.pop_front();
      if (beat[7:0] !== want.read_data) begin
        errors++;
        if (errors <= 10) $display("Beat %0d read_data: expected %h, got %h",
                                   checked, want.read_data, beat[7:0]);
      end
      if (beat[15:8] !== want.audio_level) begin
        errors++;
        if (errors <= 10) $display("Beat %0d audio_level: expected %h, got %h",
                                   checked, want.audio_level, beat[15:8]);
      end
    endfunction

    function void finish_check();
      if (expected_beats.size() != 0) begin
        errors++;
        $display("%0d expected beats never arrived", expected_beats.size());
      end
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [6:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [63:0] cfg_data = '0;

  access_scoreboard board = new();
  bit  gaps_on = 1'b1;
  int  cycles = 0;
  int  items_sent = 0;
  int  mix_writes = 0;
  int  act_seen[16];

  cartridge_data_fetcher_coprocessor #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d beats pending", cycles, board.pending());
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  initial begin : result_side
    int stall;
    logic fire;
    logic [15:0] beat;
    stall = 0;
    forever begin
      @(negedge clk);
      fire = m_tvalid && m_tready && !rst;
      beat = m_tdata;
      @(posedge clk);
      if (fire) board.check_beat(beat);
      if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
        if (gaps_on) stall = pick_gap();
      end
    end
  end

  task automatic send_access(input logic [3:0] act, input logic [2:0] ch,
                             input logic [7:0] d, input logic [10:0] sa);
    logic taken;
    int gap;
    s_tvalid <= 1'b1;
    s_tuser <= {ch, act};
    s_tdata <= {5'd0, sa, d};
    do begin
      @(negedge clk);
      taken = s_tready;
      @(posedge clk);
    end while (!taken);
    board.note_access(act, ch, d, sa);
    items_sent++;
    act_seen[act]++;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic fetch_from(input logic [3:0] act, input logic [2:0] ch);
    logic [10:0] addr;
    addr = 11'h7ff - board.fetch_cnt[ch];
    if (!board.loaded[addr]) begin
      send_access(cdfc_pkg::ACT_LOAD_STORE, 3'($urandom), 8'($urandom), addr);
    end
    send_access(act, ch, 8'($urandom), 11'($urandom));
  endtask

  task automatic write_mix(input logic [63:0] v);
    logic taken;
    if (s_tvalid) s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
    board.set_mix(v);
    mix_writes++;
  endtask

  task automatic random_block();
    int kind;
    int n;
    logic [2:0] ch;
    logic [3:0] act;
    logic [7:0] lowb;
    logic [7:0] topb;
    logic [7:0] hib;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2: begin
        ch = 3'($urandom);
        lowb = 8'($urandom);
        topb = lowb - 8'($urandom_range(0, 6));
        send_access(cdfc_pkg::ACT_COUNT_LOW, ch, lowb, 11'($urandom));
        send_access(cdfc_pkg::ACT_COUNT_HIGH, ch, 8'($urandom), 11'($urandom));
        send_access(cdfc_pkg::ACT_TOP, ch, topb, 11'($urandom));
        send_access(cdfc_pkg::ACT_BOTTOM, ch, topb - 8'($urandom_range(1, 10)),
                    11'($urandom));
        n = $urandom_range(4, 24);
        repeat (n) begin
          if ($urandom_range(0, 7) == 0)
            send_access(cdfc_pkg::ACT_READ_FLAG, ch, 8'($urandom), 11'($urandom));
          else
            fetch_from($urandom_range(0, 1) ? cdfc_pkg::ACT_FETCH_MASKED
                                            : cdfc_pkg::ACT_FETCH, ch);
        end
      end
      3, 4: begin
        ch = 3'($urandom_range(cdfc_pkg::MUSIC_FIRST, cdfc_pkg::CHANNELS - 1));
        topb = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 24));
        hib = 8'($urandom);
        hib[4] = $urandom_range(0, 5) != 0;
        send_access(cdfc_pkg::ACT_TOP, ch, topb, 11'($urandom));
        send_access(cdfc_pkg::ACT_BOTTOM, ch, 8'($urandom_range(0, topb)), 11'($urandom));
        send_access(cdfc_pkg::ACT_COUNT_LOW, ch, 8'($urandom_range(0, topb)),
                    11'($urandom));
        send_access(cdfc_pkg::ACT_COUNT_HIGH, ch, hib, 11'($urandom));
        n = $urandom_range(8, 60);
        repeat (n) begin
          case ($urandom_range(0, 7))
            0: send_access(cdfc_pkg::ACT_SOUND, 3'($urandom), 8'($urandom),
                           11'($urandom));
            1: send_access(cdfc_pkg::ACT_READ_FLAG,
                           3'($urandom_range(cdfc_pkg::MUSIC_FIRST,
                                             cdfc_pkg::CHANNELS - 1)),
                           8'($urandom), 11'($urandom));
            default: send_access(cdfc_pkg::ACT_MUSIC_TICK, 3'($urandom), 8'($urandom),
                                 11'($urandom));
          endcase
        end
      end
      default: begin
        act = 4'($urandom);
        ch = 3'($urandom);
        if (act == cdfc_pkg::ACT_FETCH || act == cdfc_pkg::ACT_FETCH_MASKED)
          fetch_from(act, ch);
        else
          send_access(act, ch, 8'($urandom), 11'($urandom));
      end
    endcase
  endtask

  initial begin : stimulus
    logic [63:0] phase_mix;
    int phase_end;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_mix(64'hffff_ffff_ffff_ffff);

    send_access(cdfc_pkg::ACT_LOAD_STORE, 3'd0, 8'hff, 11'h7ff);
    send_access(cdfc_pkg::ACT_LOAD_STORE, 3'd7, 8'h5a, 11'h000);
    fetch_from(cdfc_pkg::ACT_FETCH, 3'd0);
    fetch_from(cdfc_pkg::ACT_FETCH_MASKED, 3'd0);
    send_access(cdfc_pkg::ACT_READ_FLAG, 3'd0, 8'h00, 11'h000);
    send_access(cdfc_pkg::ACT_TOP, 3'd7, 8'hff, 11'h7ff);
    send_access(cdfc_pkg::ACT_BOTTOM, 3'd7, 8'h00, 11'h000);
    send_access(cdfc_pkg::ACT_COUNT_LOW, 3'd7, 8'hff, 11'h000);
    send_access(cdfc_pkg::ACT_COUNT_HIGH, 3'd7, 8'h17, 11'h7ff);
    fetch_from(cdfc_pkg::ACT_FETCH_MASKED, 3'd7);
    send_access(cdfc_pkg::ACT_READ_FLAG, 3'd7, 8'hff, 11'h000);
    send_access(cdfc_pkg::ACT_MUSIC_TICK, 3'd0, 8'h00, 11'h000);
    send_access(cdfc_pkg::ACT_MUSIC_TICK, 3'd7, 8'hff, 11'h7ff);
    send_access(cdfc_pkg::ACT_SOUND, 3'd0, 8'h00, 11'h000);
    send_access(cdfc_pkg::ACT_RANDOM, 3'd0, 8'h00, 11'h000);
    send_access(cdfc_pkg::ACT_RANDOM, 3'd7, 8'hff, 11'h7ff);
    send_access(cdfc_pkg::ACT_RESET_RANDOM, 3'd3, 8'hff, 11'h000);
    send_access(cdfc_pkg::ACT_RANDOM, 3'd3, 8'h00, 11'h000);
    send_access(cdfc_pkg::ACT_NULL_READ, 3'd7, 8'hff, 11'h7ff);
    send_access(cdfc_pkg::ACT_COUNT_HIGH, 3'd0, 8'hff, 11'h7ff);
    send_access(ACT_SPARE_LO, 3'd7, 8'haa, 11'h555);
    send_access(ACT_SPARE_MID, 3'd0, 8'h55, 11'h2aa);
    send_access(ACT_SPARE_HI, 3'd7, 8'hff, 11'h7ff);

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: phase_mix = 64'h0;
        2: phase_mix = 64'hffff_ffff_ffff_ffff;
        default: phase_mix = {$urandom, $urandom};
      endcase
      write_mix(phase_mix);
      gaps_on = (phase != 1);
      phase_end = items_sent + RANDOM_ITEMS / PHASES;
      while (items_sent < phase_end) random_block();
    end

    if (s_tvalid) s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    board.finish_check();
    $display("Run covered %0d accesses: %0d fetches, %0d music ticks, %0d store loads.",
             items_sent,
             act_seen[cdfc_pkg::ACT_FETCH] + act_seen[cdfc_pkg::ACT_FETCH_MASKED],
             act_seen[cdfc_pkg::ACT_MUSIC_TICK], act_seen[cdfc_pkg::ACT_LOAD_STORE]);
    $display("%0d output beats checked under %0d mix tables, %0d mismatches.",
             board.checked, mix_writes, board.errors);
    if (board.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/cdfc_pkg.sv
rtl/core/cdfc_store.sv
rtl/core/cartridge_data_fetcher_coprocessor.sv
bench/cartridge_data_fetcher_coprocessor_tb.sv
